// ===== rtl/ethernet_ipv4_header_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// Ethernet IPv4 header classifier: assertion macros
// Shared implication forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IPV4_HEADER_CLASSIFIER_DEFINES_SVH
`define ETHERNET_IPV4_HEADER_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define EIHC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eihc check failed");

// next-cycle implication
`define EIHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eihc check failed");

`endif

// ===== rtl/eihc_pkg.sv =====
// ----------------------------------------------------------------------------
// eihc_pkg
// Constants and category codes of the Ethernet IPv4 header classifier.
// ----------------------------------------------------------------------------
package eihc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [15:0] ETH_MIN_TYPE = 16'd1536;
  localparam logic [15:0] ETH_ARP      = 16'h0806;
  localparam logic [15:0] ETH_IPV4     = 16'h0800;
  localparam logic [15:0] ETH_IPV6     = 16'h86DD;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [6:0] ETH_HDR_LEN   = 7'd14;
  localparam logic [6:0] POS_ETYPE_HI  = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO  = 7'd13;
  localparam logic [6:0] POS_IHL       = 7'd14;
  localparam logic [6:0] POS_PROTO     = 7'd23;
  localparam logic [6:0] POS_SRC_IP    = 7'd26;
  localparam logic [6:0] POS_DST_IP    = 7'd30;
  localparam logic [6:0] IP_MIN_LEN    = 7'd34;
  localparam logic [6:0] TCP_NEED      = 7'd14;
  localparam logic [6:0] UDP_NEED      = 7'd4;
  localparam logic [6:0] TCP_FLAGS_OFS = 7'd13;

  localparam logic [2:0] CAT_8023      = 3'd0;
  localparam logic [2:0] CAT_ARP       = 3'd1;
  localparam logic [2:0] CAT_IPV6      = 3'd2;
  localparam logic [2:0] CAT_OTHER_NET = 3'd3;
  localparam logic [2:0] CAT_ICMP      = 3'd4;
  localparam logic [2:0] CAT_TCP       = 3'd5;
  localparam logic [2:0] CAT_UDP       = 3'd6;
  localparam logic [2:0] CAT_OTHER_TP  = 3'd7;

endpackage

// ===== rtl/ethernet_ipv4_header_classifier.sv =====
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_classifier
// Byte-stream Ethernet/IPv4/TCP/UDP header parser with one summary per frame.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | data_byte, last_byte, wire_length
//   out     | output    | out_valid / out_stall| category .. truncated
//
// One byte per cycle unless stalled; out_valid rises in the cycle after last_byte is taken.
// Capture registers update on each transfer; the summary goes to an output
// register, so the input keeps flowing while that register is free or drains.
// in_stall is high only while a summary waits under out_stall.
// Synchronous reset clears the byte counter, the capture registers and output valid.
// ----------------------------------------------------------------------------
module ethernet_ipv4_header_classifier
  import eihc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [15:0] wire_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  category,
  output logic [47:0] dst_mac,
  output logic [47:0] src_mac,
  output logic [31:0] dst_ip,
  output logic [31:0] src_ip,
  output logic [15:0] src_port,
  output logic [15:0] dst_port,
  output logic        syn_seen,
  output logic        fin_seen,
  output logic [15:0] frame_length,
  output logic        truncated
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] byte_index, byte_index_next;
  logic [15:0] ether_kind, ether_kind_next;
  logic [3:0]  header_words, header_words_next;
  logic [7:0]  ip_protocol, ip_protocol_next;
  logic [47:0] dest_hw_addr, dest_hw_addr_next;
  logic [47:0] source_hw_addr, source_hw_addr_next;
  logic [31:0] dest_net_addr, dest_net_addr_next;
  logic [31:0] source_net_addr, source_net_addr_next;
  logic [15:0] source_port_reg, source_port_reg_next;
  logic [15:0] dest_port_reg, dest_port_reg_next;
  logic [1:0]  syn_fin_bits, syn_fin_bits_next;

  logic       in_take;
  logic [6:0] tp_ofs;
  logic [6:0] need;
  logic [2:0] cat;
  logic       is_ip, has_ports, is_tcp;

  assign in_stall = out_valid & out_stall;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    ether_kind_next      = ether_kind;
    header_words_next    = header_words;
    ip_protocol_next     = ip_protocol;
    dest_hw_addr_next    = dest_hw_addr;
    source_hw_addr_next  = source_hw_addr;
    dest_net_addr_next   = dest_net_addr;
    source_net_addr_next = source_net_addr;
    source_port_reg_next = source_port_reg;
    dest_port_reg_next   = dest_port_reg;
    syn_fin_bits_next    = syn_fin_bits;
    byte_index_next      = (byte_index < COUNT_MAX) ? byte_index + 1'b1 : byte_index;

    for (int i = 0; i < 6; i++) begin
      if (byte_index == COUNT_WIDTH'(i)) dest_hw_addr_next[8*i +: 8] = data_byte;
      if (byte_index == COUNT_WIDTH'(i + 6)) source_hw_addr_next[8*i +: 8] = data_byte;
    end
    for (int i = 0; i < 4; i++) begin
      if (byte_index == COUNT_WIDTH'(POS_SRC_IP) + COUNT_WIDTH'(i))
        source_net_addr_next[8*i +: 8] = data_byte;
      if (byte_index == COUNT_WIDTH'(POS_DST_IP) + COUNT_WIDTH'(i))
        dest_net_addr_next[8*i +: 8] = data_byte;
    end
    if (byte_index == COUNT_WIDTH'(POS_ETYPE_HI)) ether_kind_next[15:8] = data_byte;
    if (byte_index == COUNT_WIDTH'(POS_ETYPE_LO)) ether_kind_next[7:0] = data_byte;
    if (byte_index == COUNT_WIDTH'(POS_IHL)) header_words_next = data_byte[3:0];
    if (byte_index == COUNT_WIDTH'(POS_PROTO)) ip_protocol_next = data_byte;

    // transport offset uses the IHL of this very byte
    tp_ofs = ETH_HDR_LEN + {1'b0, header_words_next, 2'b00};
    if (byte_index == COUNT_WIDTH'(tp_ofs)) source_port_reg_next[15:8] = data_byte;
    else if (byte_index == COUNT_WIDTH'(tp_ofs + 7'd1))
      source_port_reg_next[7:0] = data_byte;
    else if (byte_index == COUNT_WIDTH'(tp_ofs + 7'd2))
      dest_port_reg_next[15:8] = data_byte;
    else if (byte_index == COUNT_WIDTH'(tp_ofs + 7'd3))
      dest_port_reg_next[7:0] = data_byte;
    else if (byte_index == COUNT_WIDTH'(tp_ofs + TCP_FLAGS_OFS))
      syn_fin_bits_next = data_byte[1:0];
  end

  always_comb begin
    need = ETH_HDR_LEN;
    if (ether_kind_next < ETH_MIN_TYPE) cat = CAT_8023;
    else if (ether_kind_next == ETH_ARP) cat = CAT_ARP;
    else if (ether_kind_next == ETH_IPV6) cat = CAT_IPV6;
    else if (ether_kind_next != ETH_IPV4) cat = CAT_OTHER_NET;
    else begin
      need = IP_MIN_LEN;
      if (ip_protocol_next == PROTO_ICMP) cat = CAT_ICMP;
      else if (ip_protocol_next == PROTO_TCP) begin
        cat = CAT_TCP;
        if (tp_ofs + TCP_NEED > IP_MIN_LEN) need = tp_ofs + TCP_NEED;
      end else if (ip_protocol_next == PROTO_UDP) begin
        cat = CAT_UDP;
        if (tp_ofs + UDP_NEED > IP_MIN_LEN) need = tp_ofs + UDP_NEED;
      end else cat = CAT_OTHER_TP;
    end
    is_ip     = cat[2];
    has_ports = (cat == CAT_TCP) || (cat == CAT_UDP);
    is_tcp    = (cat == CAT_TCP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= '0;
      ether_kind      <= '0;
      header_words    <= '0;
      ip_protocol     <= '0;
      dest_hw_addr    <= '0;
      source_hw_addr  <= '0;
      dest_net_addr   <= '0;
      source_net_addr <= '0;
      source_port_reg <= '0;
      dest_port_reg   <= '0;
      syn_fin_bits    <= '0;
    end else if (in_take) begin
      if (last_byte) begin
        byte_index      <= '0;
        ether_kind      <= '0;
        header_words    <= '0;
        ip_protocol     <= '0;
        dest_hw_addr    <= '0;
        source_hw_addr  <= '0;
        dest_net_addr   <= '0;
        source_net_addr <= '0;
        source_port_reg <= '0;
        dest_port_reg   <= '0;
        syn_fin_bits    <= '0;
      end else begin
        byte_index      <= byte_index_next;
        ether_kind      <= ether_kind_next;
        header_words    <= header_words_next;
        ip_protocol     <= ip_protocol_next;
        dest_hw_addr    <= dest_hw_addr_next;
        source_hw_addr  <= source_hw_addr_next;
        dest_net_addr   <= dest_net_addr_next;
        source_net_addr <= source_net_addr_next;
        source_port_reg <= source_port_reg_next;
        dest_port_reg   <= dest_port_reg_next;
        syn_fin_bits    <= syn_fin_bits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && last_byte) begin
      category     <= cat;
      dst_mac      <= dest_hw_addr_next;
      src_mac      <= source_hw_addr_next;
      dst_ip       <= is_ip ? dest_net_addr_next : '0;
      src_ip       <= is_ip ? source_net_addr_next : '0;
      src_port     <= has_ports ? source_port_reg_next : '0;
      dst_port     <= has_ports ? dest_port_reg_next : '0;
      syn_seen     <= is_tcp & syn_fin_bits_next[1];
      fin_seen     <= is_tcp & syn_fin_bits_next[0];
      frame_length <= wire_length;
      // count of bytes is byte_index + 1
      truncated    <= byte_index < COUNT_WIDTH'(need - 7'd1);
    end
  end

endmodule

// ===== rtl/eihc_checker.sv =====
// ----------------------------------------------------------------------------
// eihc_checker
// Port-level checks of the Ethernet IPv4 header classifier, bound to the top.
// ----------------------------------------------------------------------------
`include "ethernet_ipv4_header_classifier_defines.svh"

module eihc_checker
  import eihc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  category,
  input logic [31:0] dst_ip,
  input logic [31:0] src_ip,
  input logic [15:0] src_port,
  input logic [15:0] dst_port,
  input logic        syn_seen,
  input logic        fin_seen
);

  `EIHC_ASSERT_NEXT(a_last_gives_result, clk, rst, in_valid && !in_stall && last_byte, out_valid)
  `EIHC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `EIHC_ASSERT_SAME(a_flags_tcp_only, clk, rst, out_valid && category != CAT_TCP, !syn_seen && !fin_seen)
  `EIHC_ASSERT_SAME(a_ports_masked, clk, rst, out_valid && category != CAT_TCP && category != CAT_UDP, src_port == 16'd0 && dst_port == 16'd0)
  `EIHC_ASSERT_SAME(a_ip_masked, clk, rst, out_valid && !category[2], src_ip == 32'd0 && dst_ip == 32'd0)

endmodule

bind ethernet_ipv4_header_classifier eihc_checker u_eihc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last_byte (last_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .category  (category),
  .dst_ip    (dst_ip),
  .src_ip    (src_ip),
  .src_port  (src_port),
  .dst_port  (dst_port),
  .syn_seen  (syn_seen),
  .fin_seen  (fin_seen)
);

// ===== test/tb_ethernet_ipv4_header_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_ethernet_ipv4_header_classifier
// Streams Ethernet frames byte by byte into the classifier, with random bursts
// and gaps on the input and random stalls on the output. Frame summaries are
// predicted per accepted byte and checked field by field in order.
// ----------------------------------------------------------------------------
module tb_ethernet_ipv4_header_classifier;
  import eihc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [15:0] wlen;
  } stim_byte_t;

  typedef struct {
    logic [2:0]  cat;
    logic [47:0] dmac;
    logic [47:0] smac;
    logic [31:0] dip;
    logic [31:0] sip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        syn;
    logic        fin;
    logic [15:0] flen;
    logic        trunc;
  } frame_summary_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic [15:0] wire_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  category;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [31:0] dst_ip;
  logic [31:0] src_ip;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic        syn_seen;
  logic        fin_seen;
  logic [15:0] frame_length;
  logic        truncated;

  ethernet_ipv4_header_classifier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte), .wire_length(wire_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .category(category), .dst_mac(dst_mac), .src_mac(src_mac),
    .dst_ip(dst_ip), .src_ip(src_ip), .src_port(src_port), .dst_port(dst_port),
    .syn_seen(syn_seen), .fin_seen(fin_seen), .frame_length(frame_length),
    .truncated(truncated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stim_byte_t     byte_q[$];
  frame_summary_t summary_q[$];
  logic [7:0]     frame_buf[$];
  bit             in_taken = 1'b0;
  int             mismatch_count = 0;
  int             summaries_seen = 0;

  // header parse state
  logic [COUNT_WIDTH_DEF-1:0] hdr_cnt = '0;
  logic [15:0] p_etype = '0;
  logic [3:0]  p_ihl = '0;
  logic [7:0]  p_proto = '0;
  logic [47:0] p_dmac = '0;
  logic [47:0] p_smac = '0;
  logic [31:0] p_dip = '0;
  logic [31:0] p_sip = '0;
  logic [15:0] p_sport = '0;
  logic [15:0] p_dport = '0;
  logic [1:0]  p_flags = '0;

  task automatic parse_byte(input logic [7:0] b, input logic last, input logic [15:0] wlen);
    int pos, t, need, count;
    frame_summary_t s;
    logic ip_like, has_ports;
    pos = int'(hdr_cnt);
    if (pos < 6) p_dmac[8*pos +: 8] = b;
    else if (pos < 12) p_smac[8*(pos-6) +: 8] = b;
    else if (pos == POS_ETYPE_HI) p_etype[15:8] = b;
    else if (pos == POS_ETYPE_LO) p_etype[7:0] = b;
    else if (pos == POS_IHL) p_ihl = b[3:0];
    else if (pos == POS_PROTO) p_proto = b;
    else if (pos >= POS_SRC_IP && pos < POS_SRC_IP + 4) p_sip[8*(pos-POS_SRC_IP) +: 8] = b;
    else if (pos >= POS_DST_IP && pos < POS_DST_IP + 4) p_dip[8*(pos-POS_DST_IP) +: 8] = b;
    t = int'(ETH_HDR_LEN) + 4 * int'(p_ihl);
    if (pos == t) p_sport[15:8] = b;
    else if (pos == t + 1) p_sport[7:0] = b;
    else if (pos == t + 2) p_dport[15:8] = b;
    else if (pos == t + 3) p_dport[7:0] = b;
    else if (pos == t + TCP_FLAGS_OFS) p_flags = b[1:0];
    count = pos + 1;
    if (hdr_cnt != '1) hdr_cnt = hdr_cnt + 1'b1;
    if (last) begin
      need = ETH_HDR_LEN;
      if (p_etype < ETH_MIN_TYPE) s.cat = CAT_8023;
      else if (p_etype == ETH_ARP) s.cat = CAT_ARP;
      else if (p_etype == ETH_IPV6) s.cat = CAT_IPV6;
      else if (p_etype != ETH_IPV4) s.cat = CAT_OTHER_NET;
      else begin
        need = IP_MIN_LEN;
        if (p_proto == PROTO_ICMP) s.cat = CAT_ICMP;
        else if (p_proto == PROTO_TCP) begin
          s.cat = CAT_TCP;
          need = t + TCP_NEED;
        end else if (p_proto == PROTO_UDP) begin
          s.cat = CAT_UDP;
          need = t + UDP_NEED;
        end else s.cat = CAT_OTHER_TP;
        if (need < IP_MIN_LEN) need = IP_MIN_LEN;
      end
      ip_like = s.cat >= CAT_ICMP;
      has_ports = (s.cat == CAT_TCP) || (s.cat == CAT_UDP);
      s.dmac = p_dmac;
      s.smac = p_smac;
      s.dip = ip_like ? p_dip : '0;
      s.sip = ip_like ? p_sip : '0;
      s.sport = has_ports ? p_sport : '0;
      s.dport = has_ports ? p_dport : '0;
      s.syn = (s.cat == CAT_TCP) ? p_flags[1] : 1'b0;
      s.fin = (s.cat == CAT_TCP) ? p_flags[0] : 1'b0;
      s.flen = wlen;
      s.trunc = count < need;
      summary_q.push_back(s);
      hdr_cnt = '0;
      p_etype = '0;
      p_ihl = '0;
      p_proto = '0;
      p_dmac = '0;
      p_smac = '0;
      p_dip = '0;
      p_sip = '0;
      p_sport = '0;
      p_dport = '0;
      p_flags = '0;
    end
  endtask

  function automatic void note_mismatch(string what, logic [63:0] e, logic [63:0] a);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, e, a);
  endfunction

  function automatic void check_field(string what, logic [63:0] e, logic [63:0] a);
    if (e !== a) note_mismatch(what, e, a);
  endfunction

  // input acceptance and summary checking
  always @(posedge clk) begin
    frame_summary_t s;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        parse_byte(data_byte, last_byte, wire_length);
      end
      if (out_valid && !out_stall) begin
        summaries_seen++;
        if (summary_q.size() == 0) note_mismatch("unexpected summary, category", '0, category);
        else begin
          s = summary_q.pop_front();
          check_field("category", s.cat, category);
          check_field("dst_mac", s.dmac, dst_mac);
          check_field("src_mac", s.smac, src_mac);
          check_field("dst_ip", s.dip, dst_ip);
          check_field("src_ip", s.sip, src_ip);
          check_field("src_port", s.sport, src_port);
          check_field("dst_port", s.dport, dst_port);
          check_field("syn_seen", s.syn, syn_seen);
          check_field("fin_seen", s.fin, fin_seen);
          check_field("frame_length", s.flen, frame_length);
          check_field("truncated", s.trunc, truncated);
        end
      end
    end
  end

  // byte driver: random bursts and gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    stim_byte_t sb;
    if (rst) in_valid <= 1'b0;
    else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        sb = byte_q.pop_front();
        data_byte <= sb.data;
        last_byte <= sb.last;
        wire_length <= sb.wlen;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else in_valid <= 1'b0;
    end
  end

  // summary receiver: stall modes plus one long hold-off
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && summaries_seen >= 20) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        default:      out_stall <= ~out_stall;
      endcase
    end
  end

  function automatic void place(int pos, logic [7:0] val);
    if (pos < frame_buf.size()) frame_buf[pos] = val;
  endfunction

  task automatic emit_frame();
    stim_byte_t sb;
    foreach (frame_buf[i]) begin
      sb.data = frame_buf[i];
      sb.last = (i == frame_buf.size() - 1);
      sb.wlen = 16'($urandom);
      if (sb.last) begin
        case ($urandom_range(0, 3))
          0: sb.wlen = '0;
          1: sb.wlen = '1;
          default: ;
        endcase
      end
      byte_q.push_back(sb);
    end
  endtask

  // keep > 0: exact length, keep == 0: full headers, keep < 0: random cut
  task automatic build_frame(input logic [15:0] etype, input logic [7:0] proto,
                             input logic [3:0] ihl, input logic [7:0] flags, input int keep);
    int t, full, n;
    t = int'(ETH_HDR_LEN) + 4 * int'(ihl);
    if (etype == ETH_IPV4)
      full = ((t + TCP_NEED > IP_MIN_LEN) ? t + TCP_NEED : IP_MIN_LEN) + $urandom_range(0, 12);
    else full = ETH_HDR_LEN + $urandom_range(0, 46);
    if (keep > 0) n = keep;
    else if (keep < 0) n = $urandom_range(1, full);
    else n = full;
    frame_buf.delete();
    repeat (n) frame_buf.push_back(8'($urandom));
    place(POS_ETYPE_HI, etype[15:8]);
    place(POS_ETYPE_LO, etype[7:0]);
    if (etype == ETH_IPV4) begin
      place(POS_IHL, {4'h4, ihl});
      place(POS_PROTO, proto);
      place(t + TCP_FLAGS_OFS, flags);
    end
    emit_frame();
  endtask

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int rand_frames, r, pick_keep;
    logic [3:0] ihl;
    logic [15:0] etype;
    logic [7:0] proto;

    // directed frames
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    emit_frame();
    build_frame(ETH_IPV4, PROTO_TCP, 4'd5, 8'h03, 13);
    build_frame(16'h0000, 8'h00, 4'd5, 8'h00, 0);
    build_frame(ETH_MIN_TYPE - 1'b1, 8'h00, 4'd5, 8'h00, 0);
    build_frame(ETH_MIN_TYPE, 8'h00, 4'd5, 8'h00, 0);
    build_frame(ETH_ARP, 8'h00, 4'd5, 8'h00, 0);
    build_frame(ETH_IPV6, 8'h00, 4'd5, 8'h00, 0);
    build_frame(16'hFFFF, 8'h00, 4'd5, 8'h00, 0);
    build_frame(ETH_IPV4, PROTO_ICMP, 4'd5, 8'h00, 0);
    build_frame(ETH_IPV4, PROTO_TCP, 4'd5, 8'hFF, 0);
    build_frame(ETH_IPV4, PROTO_TCP, 4'd5, 8'h00, 0);
    build_frame(ETH_IPV4, PROTO_UDP, 4'd5, 8'hFF, 0);
    build_frame(ETH_IPV4, 8'hFF, 4'd5, 8'h00, 0);
    build_frame(ETH_IPV4, 8'h00, 4'd5, 8'h00, 0);
    build_frame(ETH_IPV4, PROTO_TCP, 4'd15, 8'h02, 0);
    build_frame(ETH_IPV4, PROTO_TCP, 4'd0, 8'h01, 0);
    build_frame(ETH_IPV4, PROTO_UDP, 4'd1, 8'h00, 0);
    build_frame(ETH_IPV4, PROTO_TCP, 4'd5, 8'h03, 40);
    build_frame(ETH_IPV4, PROTO_UDP, 4'd5, 8'h00, 37);
    build_frame(ETH_IPV4, PROTO_ICMP, 4'd5, 8'h00, 33);
    build_frame(ETH_IPV4, PROTO_ICMP, 4'd5, 8'h00, 34);
    build_frame(ETH_IPV4, PROTO_TCP, 4'd5, 8'h01, 48);
    frame_buf.delete();
    repeat (64) frame_buf.push_back(8'h00);
    emit_frame();
    frame_buf.delete();
    repeat (64) frame_buf.push_back(8'hFF);
    emit_frame();

    // random frames, mostly well formed
    rand_frames = 0;
    while (byte_q.size() < 2000 || rand_frames < 20) begin
      r = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
      pick_keep = ($urandom_range(0, 6) == 0) ? -1 : 0;
      proto = 8'($urandom);
      etype = ETH_IPV4;
      if (r < 30) proto = PROTO_TCP;
      else if (r < 50) proto = PROTO_UDP;
      else if (r < 58) proto = PROTO_ICMP;
      else if (r < 63) ;
      else if (r < 70) etype = ETH_ARP;
      else if (r < 75) etype = ETH_IPV6;
      else if (r < 82) etype = 16'($urandom_range(0, 1535));
      else etype = 16'($urandom);
      if (r >= 88) begin
        frame_buf.delete();
        repeat ($urandom_range(1, 80)) frame_buf.push_back(8'($urandom));
        emit_frame();
      end else build_frame(etype, proto, ihl, 8'($urandom), pick_keep);
      rand_frames++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (byte_q.size() != 0 || in_valid || summary_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatch_count == 0 && summary_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
